/* src/kuznyechik_cmac_tag_unit_assert.svh */
// Assertion macros shared by the tag unit modules
`ifndef KUZNYECHIK_CMAC_TAG_UNIT_ASSERT_SVH
`define KUZNYECHIK_CMAC_TAG_UNIT_ASSERT_SVH

// Check that an antecedent implies a consequent in the same cycle
`define KCT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Check that an antecedent implies a consequent in the next cycle
`define KCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* src/kct_pkg.sv */
// Package: cipher tables, round function and shared command types
package kct_pkg;

  localparam int unsigned BlkW = 128;
  localparam int unsigned NumRk = 10;
  localparam int unsigned RkIdxW = 4;
  localparam int unsigned KeyRegs = 4;
  localparam int unsigned AddrW = 5;
  localparam int unsigned FeistelRounds = 32;
  localparam logic [7:0] RbConst = 8'h87;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [7:0] byte_t;

  localparam byte_t PiBox [256] = '{
    8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
    8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
    8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
    8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
    8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
    8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
    8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
    8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
    8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
    8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
    8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
    8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
    8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
    8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
    8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
    8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
    8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
    8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
    8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
    8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
    8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
    8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
    8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
    8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
    8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
    8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
    8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
    8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
    8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
    8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
    8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
    8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
  };

  localparam byte_t LinCoef [16] = '{
    8'd148,8'd32,8'd133,8'd16,8'd194,8'd192,8'd1,8'd251,
    8'd1,8'd192,8'd194,8'd16,8'd133,8'd32,8'd148,8'd1
  };

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    logic [8:0] x;
    byte_t r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) x = x ^ 9'h1C3;
    end
    return r;
  endfunction

  // Byte i sits at bits 127-8i
  function automatic byte_t get_byte(logic [BlkW-1:0] v, int i);
    return v[BlkW-1-8*i -: 8];
  endfunction

  // One step of the linear map: shift right one byte, new byte 0
  function automatic logic [BlkW-1:0] r_step(logic [BlkW-1:0] v);
    byte_t t;
    t = '0;
    for (int i = 0; i < 16; i++) t = t ^ gf_mul(get_byte(v, i), LinCoef[i]);
    return {t, v[BlkW-1:8]};
  endfunction

  // Full linear map, used only on constants at elaboration
  function automatic logic [BlkW-1:0] lin_map(logic [BlkW-1:0] v);
    logic [BlkW-1:0] x;
    x = v;
    for (int r = 0; r < 16; r++) x = r_step(x);
    return x;
  endfunction

  function automatic logic [BlkW-1:0] sub_bytes(logic [BlkW-1:0] v);
    logic [BlkW-1:0] o;
    for (int i = 0; i < 16; i++) o[BlkW-1-8*i -: 8] = PiBox[get_byte(v, i)];
    return o;
  endfunction

  function automatic logic [BlkW-1:0] dbl(logic [BlkW-1:0] v);
    return {v[BlkW-2:0], 1'b0} ^ {120'd0, v[BlkW-1] ? RbConst : 8'h00};
  endfunction

  // Command from controller to datapath
  typedef enum logic [3:0] {
    OP_NONE, OP_KEY_LOAD, OP_FEI_SUB, OP_FEI_LIN, OP_FEI_STORE,
    OP_ENC_START, OP_ENC_SUB, OP_ENC_LIN, OP_ENC_FINAL,
    OP_SUBKEYS, OP_MSG_START
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [4:0]  cnt;   // Feistel round index (0..31)
    logic [3:0]  rk;    // round key index
    logic        lin_last;
  } cmd_t;

  typedef struct packed {
    logic [4:0] byte_count;
    logic       last;
  } item_t;

endpackage

/* src/kct_if.sv */
// Valid/ready channel interfaces for message blocks and tags
interface kct_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_hi;
  logic [63:0] data_lo;
  logic [4:0]  byte_count;
  logic        last;
  modport source (output valid, data_hi, data_lo, byte_count, last, input ready);
  modport sink (input valid, data_hi, data_lo, byte_count, last, output ready);
endinterface

interface kct_tag_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_hi;
  logic [63:0] tag_lo;
  modport source (output valid, tag_hi, tag_lo, input ready);
  modport sink (input valid, tag_hi, tag_lo, output ready);
endinterface

/* src/kct_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read
module kct_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* src/kct_datapath.sv */
// Datapath: key schedule state, cipher state, chain and subkeys
module kct_datapath
  import kct_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmd_t            cmd_i,
  input  logic [255:0]    key_i,
  input  logic [BlkW-1:0] blk_i,
  input  item_t           item_i,
  output logic [BlkW-1:0] tag_o
);
  `include "kuznyechik_cmac_tag_unit_assert.svh"

  logic [BlkW-1:0] a1_q, a1_d, a0_q, a0_d, st_q, st_d, chain_q, chain_d;
  logic [BlkW-1:0] k1_q, k1_d, k2_q, k2_d, tmp_q, tmp_d;
  logic            is_last_q, is_last_d, zero_run_q, zero_run_d;
  logic            rk_we;
  logic [RkIdxW-1:0] rk_waddr, rk_raddr;
  logic [BlkW-1:0] rk_wdata, rk_rdata;
  logic [BlkW-1:0] cst_tab [FeistelRounds];
  logic [BlkW-1:0] padded, mask, padbit, msg_in;
  logic [4:0]      cnt_sat;

  for (genvar g = 0; g < FeistelRounds; g++) begin : g_cst
    assign cst_tab[g] = lin_map({120'd0, 8'(g + 1)});
  end

  kct_ram #(.Width(BlkW), .Depth(NumRk)) u_rk_ram (
    .clk_i, .we_i(rk_we), .waddr_i(rk_waddr), .wdata_i(rk_wdata),
    .raddr_i(rk_raddr), .rdata_o(rk_rdata)
  );

  assign rk_raddr = cmd_i.rk;

  always_comb begin
    cnt_sat = (item_i.byte_count > 5'd16) ? 5'd16 : item_i.byte_count;
    mask = '0;
    padbit = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < cnt_sat) mask[BlkW-1-8*i -: 8] = 8'hFF;
      if (5'(i) == cnt_sat) padbit[BlkW-1-8*i -: 8] = PadByte;
    end
    padded = (blk_i & mask) | padbit;
    if (!item_i.last) msg_in = blk_i;
    else if (cnt_sat == 5'd16) msg_in = blk_i ^ k1_q;
    else msg_in = padded ^ k2_q;
  end

  always_comb begin
    a1_d = a1_q; a0_d = a0_q; st_d = st_q; chain_d = chain_q;
    k1_d = k1_q; k2_d = k2_q; tmp_d = tmp_q;
    is_last_d = is_last_q; zero_run_d = zero_run_q;
    rk_we = 1'b0; rk_waddr = '0; rk_wdata = '0;
    unique case (cmd_i.op)
      OP_KEY_LOAD: begin
        a1_d = key_i[255:128];
        a0_d = key_i[127:0];
        rk_we = 1'b1; rk_waddr = cmd_i.rk;
        rk_wdata = (cmd_i.rk == '0) ? key_i[255:128] : key_i[127:0];
      end
      OP_FEI_SUB: tmp_d = sub_bytes(a1_q ^ cst_tab[cmd_i.cnt]);
      OP_FEI_LIN: begin
        tmp_d = r_step(tmp_q);
        if (cmd_i.lin_last) begin
          a1_d = r_step(tmp_q) ^ a0_q;
          a0_d = a1_q;
        end
      end
      OP_FEI_STORE: begin
        rk_we = 1'b1; rk_waddr = cmd_i.rk;
        rk_wdata = (cmd_i.rk[0] == 1'b0) ? a1_q : a0_q;
      end
      OP_MSG_START: begin
        st_d = chain_q ^ msg_in;
        is_last_d = item_i.last;
        zero_run_d = 1'b0;
      end
      OP_ENC_START: begin
        st_d = '0;
        is_last_d = 1'b0;
        zero_run_d = 1'b1;
      end
      OP_ENC_SUB: tmp_d = sub_bytes(st_q ^ rk_rdata);
      OP_ENC_LIN: begin
        tmp_d = r_step(tmp_q);
        if (cmd_i.lin_last) st_d = r_step(tmp_q);
      end
      OP_ENC_FINAL: begin
        st_d = st_q ^ rk_rdata;
        if (!zero_run_q) chain_d = is_last_q ? '0 : (st_q ^ rk_rdata);
      end
      OP_SUBKEYS: begin
        k1_d = dbl(st_q);
        k2_d = dbl(dbl(st_q));
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
      is_last_q <= 1'b0;
      zero_run_q <= 1'b0;
    end else begin
      chain_q <= chain_d;
      is_last_q <= is_last_d;
      zero_run_q <= zero_run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= a1_d; a0_q <= a0_d; st_q <= st_d; k1_q <= k1_d;
    k2_q <= k2_d; tmp_q <= tmp_d;
  end

  assign tag_o = st_q;

  `KCT_ASSERT_NEXT(a_chain_clear, clk_i, rst_ni,
    cmd_i.op == OP_ENC_FINAL && is_last_q, chain_q == '0)
  `KCT_ASSERT_IMPL(a_rk_write_idx, clk_i, rst_ni, rk_we, rk_waddr < RkIdxW'(NumRk))
  `KCT_ASSERT_NEXT(a_enc_start_zero, clk_i, rst_ni, cmd_i.op == OP_ENC_START, st_q == '0)
endmodule

/* src/kct_ctrl.sv */
// Controller: sequences key expansion, block encryption and handshakes
module kct_ctrl
  import kct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic key_wr_i,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic out_load_o,
  output cmd_t cmd_o
);
  `include "kuznyechik_cmac_tag_unit_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_KLOAD, S_FSUB, S_FLIN, S_FSTORE, S_ESTART, S_ESUB, S_ELIN,
    S_EFIN, S_SUBK, S_OUT
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [3:0] rk_q, rk_d;
  logic [3:0] lin_q, lin_d;
  logic       kexp_q, kexp_d, pend_q, pend_d, last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE) && !pend_q && !key_wr_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rk_d = rk_q; lin_d = lin_q;
    kexp_d = kexp_q; pend_d = pend_q; last_d = last_q;
    out_valid_d = out_valid_q;
    cmd_o = '{op: OP_NONE, cnt: cnt_q, rk: rk_q, lin_last: lin_q == 4'd15};
    out_load_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (key_wr_i || pend_q) begin
          pend_d = 1'b0;
          state_d = S_KLOAD;
          rk_d = '0;
        end else if (accept) begin
          cmd_o.op = OP_MSG_START;
          last_d = in_last_i;
          kexp_d = 1'b0;
          rk_d = '0;
          state_d = S_ESUB;
        end
      end
      S_KLOAD: begin
        cmd_o.op = OP_KEY_LOAD;
        if (rk_q == 4'd1) begin
          cnt_d = '0; state_d = S_FSUB;
        end else begin
          rk_d = rk_q + 4'd1;
        end
      end
      S_FSUB: begin
        cmd_o.op = OP_FEI_SUB;
        lin_d = '0;
        state_d = S_FLIN;
      end
      S_FLIN: begin
        cmd_o.op = OP_FEI_LIN;
        lin_d = lin_q + 4'd1;
        if (lin_q == 4'd15) begin
          cnt_d = cnt_q + 5'd1;
          if (cnt_q[2:0] == 3'd7) begin
            rk_d = {1'b0, cnt_q[4:3], 1'b0} + 4'd2;
            state_d = S_FSTORE;
          end else begin
            state_d = S_FSUB;
          end
        end
      end
      S_FSTORE: begin
        cmd_o.op = OP_FEI_STORE;
        if (rk_q[0] == 1'b0) begin
          rk_d = rk_q + 4'd1;
        end else if (cnt_q == '0) begin
          kexp_d = 1'b1;
          rk_d = '0;
          state_d = S_ESTART;
        end else begin
          state_d = S_FSUB;
        end
      end
      S_ESTART: begin
        cmd_o.op = OP_ENC_START;
        state_d = S_ESUB;
      end
      S_ESUB: begin
        cmd_o.op = OP_ENC_SUB;
        lin_d = '0;
        state_d = S_ELIN;
      end
      S_ELIN: begin
        cmd_o.op = OP_ENC_LIN;
        lin_d = lin_q + 4'd1;
        if (lin_q == 4'd0) rk_d = rk_q + 4'd1;
        if (lin_q == 4'd15) begin
          state_d = (rk_q == 4'd9) ? S_EFIN : S_ESUB;
        end
      end
      S_EFIN: begin
        cmd_o.op = OP_ENC_FINAL;
        rk_d = '0;
        if (kexp_q) state_d = S_SUBK;
        else if (last_q) state_d = S_OUT;
        else state_d = S_IDLE;
      end
      S_SUBK: begin
        cmd_o.op = OP_SUBKEYS;
        kexp_d = 1'b0;
        state_d = S_IDLE;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load_o = 1'b1;
          last_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (key_wr_i && state_q != S_IDLE) pend_d = 1'b1;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load_o) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; rk_q <= '0; lin_q <= '0;
      kexp_q <= 1'b0; pend_q <= 1'b0; last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; rk_q <= rk_d; lin_q <= lin_d;
      kexp_q <= kexp_d; pend_q <= pend_d; last_q <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `KCT_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, accept, state_q == S_IDLE)
  `KCT_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `KCT_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, accept, state_q == S_ESUB)
  `KCT_ASSERT_IMPL(a_load_free, clk_i, rst_ni, out_load_o, !out_valid_q || out_ready_i)
endmodule

/* src/kuznyechik_cmac_tag_unit.sv */
// Top level: CMAC tag unit over the Kuznyechik cipher with APB key port
//   channel   dir  beat
//   blk_if    in   data_hi, data_lo, byte_count, last
//   tag_if    out  tag_hi, tag_lo (after a last block only)
//   apb       in   key_word_0..3 at 8*i, 64-bit data
// A block runs from accept through nine rounds (one S-box step and sixteen
// linear steps each) to the final key XOR; the next block is accepted only
// after that, and a last block also passes through the output state.
// A key write reruns expansion: load of the two key halves, 32 Feistel
// rounds of one S-box step and sixteen linear steps, storing of eight round
// keys, a state clear, the encryption of zero and the subkey step.
// Reset clears the key registers, chain and control; round keys are undefined.
// The tag is held in an output register until taken; a later last block
// stalls until that register is free.
module kuznyechik_cmac_tag_unit
  import kct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  kct_blk_if.sink           blk_if,
  kct_tag_if.source         tag_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  logic [63:0]     key_q [KeyRegs];
  logic            wr_en, key_wr, out_load;
  logic [1:0]      widx;
  logic [BlkW-1:0] tag_raw;
  logic [BlkW-1:0] tag_q;
  cmd_t            cmd;
  item_t           item;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign widx = paddr[4:3];
  assign key_wr = wr_en && (paddr[2:0] == 3'd0);
  assign prdata = key_q[paddr[4:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KeyRegs; i++) key_q[i] <= '0;
    end else if (key_wr) begin
      key_q[widx] <= pwdata;
    end
  end

  assign item = '{byte_count: blk_if.byte_count, last: blk_if.last};

  kct_ctrl u_ctrl (
    .clk_i, .rst_ni, .key_wr_i(key_wr), .in_valid_i(blk_if.valid),
    .in_last_i(blk_if.last), .in_ready_o(blk_if.ready),
    .out_valid_o(tag_if.valid), .out_ready_i(tag_if.ready),
    .out_load_o(out_load), .cmd_o(cmd)
  );

  kct_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .key_i({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .blk_i({blk_if.data_hi, blk_if.data_lo}), .item_i(item), .tag_o(tag_raw)
  );

  always_ff @(posedge clk_i) begin
    if (out_load) tag_q <= tag_raw ^ '0;
  end

  assign tag_if.tag_hi = tag_q[BlkW-1:64];
  assign tag_if.tag_lo = tag_q[63:0];
endmodule
